@@ hdl/ard_pkg.sv @@
// Shared types, constants and register indexes for the archive record deframer.
package ard_pkg;

    // Longest name that can match, and the bytes held in the name registers
    localparam int NAME_MAX_BYTES   = 32;
    localparam int NAME_STORE_BYTES = 32;
    localparam int NAME_IDX_W       = $clog2(NAME_STORE_BYTES);

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int NAME_LEN_W  = 6;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LEN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_W0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_W1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_W2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_W3  = 3'd4;

    // Index of the last byte of a 4-byte length field
    localparam logic [1:0] LEN_LAST_BYTE = 2'd3;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Parser phase
    typedef enum logic [3:0] {
        PH_NAME_LEN    = 4'b0001,
        PH_NAME        = 4'b0010,
        PH_CONTENT_LEN = 4'b0100,
        PH_CONTENT     = 4'b1000
    } phase_t;

    // One result request
    typedef struct packed {
        logic [7:0] content_byte;
        logic       record_start;
        logic       record_end;
    } item_t;

endpackage

@@ hdl/ard_front.sv @@
// Front part: configuration registers, record parser and name compare.
module ard_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ard_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ard_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            q_full,
    output logic                            q_push,
    output ard_pkg::item_t                  q_item
);

    logic [ard_pkg::NAME_LEN_W-1:0]                   tlen_reg;
    logic [ard_pkg::NAME_STORE_BYTES-1:0][7:0]        name_reg;

    ard_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     fc_reg, fc_next;
    logic [23:0]     gather_reg, gather_next;
    logic [31:0]     fl_reg, fl_next;
    logic            name_equal_reg, name_equal_next;
    logic            match_reg, match_next;

    logic            accept;
    logic [32:0]     fc_plus1;
    logic            last;
    logic [31:0]     len_value;
    logic [31:0]     len_span;
    logic            fc_in_target;
    logic [7:0]      tbyte;
    logic            name_eq_new;
    logic            tlen_ok;
    logic            match_new;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg <= '0;
            name_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ard_pkg::REG_NAME_LEN: tlen_reg       <= cfg_data[ard_pkg::NAME_LEN_W-1:0];
                ard_pkg::REG_NAME_W0:  name_reg[7:0]   <= cfg_data;
                ard_pkg::REG_NAME_W1:  name_reg[15:8]  <= cfg_data;
                ard_pkg::REG_NAME_W2:  name_reg[23:16] <= cfg_data;
                ard_pkg::REG_NAME_W3:  name_reg[31:24] <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Field end, length decode and name byte compare
    always_comb
    begin
        fc_plus1     = {1'b0, fc_reg} + 33'd1;
        last         = fc_plus1 >= {1'b0, fl_reg};
        len_value    = {data_byte, gather_reg};
        len_span     = ((len_value == 32'd0) || data_byte[7]) ? 32'd1 : len_value;
        fc_in_target = fc_reg < {{(32-ard_pkg::NAME_LEN_W){1'b0}}, tlen_reg};
        tbyte        = (|fc_reg[31:ard_pkg::NAME_IDX_W]) ? 8'd0
                       : name_reg[fc_reg[ard_pkg::NAME_IDX_W-1:0]];
        name_eq_new  = name_equal_reg && !(fc_in_target && (data_byte != tbyte));
        tlen_ok      = (tlen_reg != '0)
                       && (tlen_reg <= ard_pkg::NAME_LEN_W'(ard_pkg::NAME_MAX_BYTES));
        match_new    = name_eq_new && tlen_ok
                       && (fl_reg == {{(32-ard_pkg::NAME_LEN_W){1'b0}}, tlen_reg});
    end

    // Advance the parser on each accepted byte
    always_comb
    begin
        phase_next      = phase_reg;
        fc_next         = fc_reg;
        gather_next     = gather_reg;
        fl_next         = fl_reg;
        name_equal_next = name_equal_reg;
        match_next      = match_reg;
        if (accept)
        begin
            unique case (phase_reg)
                ard_pkg::PH_NAME_LEN, ard_pkg::PH_CONTENT_LEN:
                begin
                    if (fc_reg[1:0] != ard_pkg::LEN_LAST_BYTE)
                    begin
                        case (fc_reg[1:0])
                            2'd0:    gather_next[7:0]   = data_byte;
                            2'd1:    gather_next[15:8]  = data_byte;
                            default: gather_next[23:16] = data_byte;
                        endcase
                        fc_next = fc_plus1[31:0];
                    end
                    else
                    begin
                        fl_next     = len_span;
                        gather_next = '0;
                        fc_next     = '0;
                        if (phase_reg == ard_pkg::PH_NAME_LEN)
                        begin
                            name_equal_next = 1'b1;
                            phase_next      = ard_pkg::PH_NAME;
                        end
                        else
                        begin
                            phase_next = ard_pkg::PH_CONTENT;
                        end
                    end
                end
                ard_pkg::PH_NAME:
                begin
                    name_equal_next = name_eq_new;
                    if (last)
                    begin
                        match_next = match_new;
                        fc_next    = '0;
                        phase_next = ard_pkg::PH_CONTENT_LEN;
                    end
                    else
                    begin
                        fc_next = fc_plus1[31:0];
                    end
                end
                ard_pkg::PH_CONTENT:
                begin
                    if (last)
                    begin
                        fc_next    = '0;
                        match_next = 1'b0;
                        phase_next = ard_pkg::PH_NAME_LEN;
                    end
                    else
                    begin
                        fc_next = fc_plus1[31:0];
                    end
                end
                default:
                begin
                    phase_next = ard_pkg::PH_NAME_LEN;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ard_pkg::PH_NAME_LEN;
            fc_reg         <= '0;
            gather_reg     <= '0;
            fl_reg         <= '0;
            name_equal_reg <= 1'b1;
            match_reg      <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            fc_reg         <= fc_next;
            gather_reg     <= gather_next;
            fl_reg         <= fl_next;
            name_equal_reg <= name_equal_next;
            match_reg      <= match_next;
        end
    end

    // Queue a result request for content of a matching record
    assign q_push              = accept && (phase_reg == ard_pkg::PH_CONTENT) && match_reg;
    assign q_item.content_byte = data_byte;
    assign q_item.record_start = (fc_reg == 32'd0);
    assign q_item.record_end   = last;

endmodule

@@ hdl/ard_queue.sv @@
// Short result queue between the parser and the output stage.
module ard_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ard_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output ard_pkg::item_t pop_item,
    output logic           empty
);

    ard_pkg::item_t                mem_reg [ard_pkg::QUEUE_DEPTH];
    logic [ard_pkg::QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [ard_pkg::QUEUE_AW:0]    count_reg, count_next;

    assign full     = (count_reg == (ard_pkg::QUEUE_AW+1)'(ard_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/ard_back.sv @@
// Back part: output register that delivers queued results downstream.
module ard_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  ard_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     content_byte,
    output logic           record_start,
    output logic           record_end
);

    logic           out_valid_reg;
    ard_pkg::item_t out_item_reg;

    // Load when the register is empty or being drained
    assign q_pop = !q_empty && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold payload until taken
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_item_reg <= q_item;
        end
    end

    assign out_valid    = out_valid_reg;
    assign content_byte = out_item_reg.content_byte;
    assign record_start = out_item_reg.record_start;
    assign record_end   = out_item_reg.record_end;

endmodule

@@ hdl/archive_record_deframer_unit.sv @@
// Archive record deframer: passes out content bytes of the record whose name matches.
//
// Input channel (in_valid/in_ready/data_byte) takes one archive body byte per
// request. Records are a 4-byte little-endian name length, the name, a 4-byte
// content length and the content; a length of zero or below spans one byte.
// Output channel (out_valid/out_ready) carries content_byte with record_start on
// the first and record_end on the last content byte of a matching record. On
// record_start the receiver drops whatever it kept from an earlier match.
// Configuration: write cfg_data to register cfg_index when cfg_write is high:
// 0 name length, 1..4 name bytes 0..31 packed little-endian, eight per word.
// Throughput: one byte per cycle while the result queue has room (in_ready high).
// A content byte passes through the result queue and then the output register.
// A stalled receiver fills the 4-entry result queue; in_ready then drops until
// the output register drains. Bytes of other records never occupy the queue.
// Reset clears the parser, queue, output valid and the configuration registers.
module archive_record_deframer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ard_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ard_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      content_byte,
    output logic                            record_start,
    output logic                            record_end
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    ard_pkg::item_t push_item;
    ard_pkg::item_t pop_item;

    ard_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    ard_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    ard_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .content_byte (content_byte),
        .record_start (record_start),
        .record_end   (record_end)
    );

endmodule

@@ hdl/ard_checker.sv @@
// Port-level checks on the deframer output and their binding to the top level.
module ard_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] content_byte,
    input logic       record_start,
    input logic       record_end
);

    logic in_record_reg;

    // Track whether delivered bytes are inside a record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_record_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            in_record_reg <= !record_end;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(content_byte) && $stable(record_start) && $stable(record_end))
        else $error("output payload changed while stalled");

    a_start_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_record_reg |-> record_start)
        else $error("record began without record_start");

    a_no_start_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_record_reg |-> !record_start)
        else $error("record_start inside an unfinished record");

endmodule

bind archive_record_deframer_unit ard_checker u_ard_checker (.*);
